// ===== sv/kiac_pkg.sv =====
package kiac_pkg;

  typedef enum logic [2:0] {
    MODE_UNSET  = 3'd0,
    MODE_EXIT   = 3'd1,
    MODE_SET    = 3'd2,
    MODE_ENTRY  = 3'd3,
    MODE_ALARM  = 3'd4,
    MODE_REPORT = 3'd5
  } mode_t;

  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_ON    = 2'd1;
  localparam logic [1:0] LAMP_BLINK = 2'd2;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_WRONG   = 2'd1;
  localparam logic [1:0] REASON_ZONE    = 2'd2;
  localparam logic [1:0] REASON_TIMEOUT = 2'd3;

  localparam logic [3:0] KEY_B = 4'd11;
  localparam logic [3:0] KEY_C = 4'd12;

  localparam logic [2:0] REG_SECRET_CODE   = 3'd0;
  localparam logic [2:0] REG_EXIT_SECONDS  = 3'd1;
  localparam logic [2:0] REG_ENTRY_SECONDS = 3'd2;
  localparam logic [2:0] REG_ALARM_SECONDS = 3'd3;
  localparam logic [2:0] REG_WRONG_LIMIT   = 3'd4;

  localparam logic [15:0] SECRET_CODE_RESET   = 16'h1234;
  localparam logic [7:0]  EXIT_SECONDS_RESET  = 8'd60;
  localparam logic [7:0]  ENTRY_SECONDS_RESET = 8'd120;
  localparam logic [7:0]  ALARM_SECONDS_RESET = 8'd120;
  localparam logic [3:0]  WRONG_LIMIT_RESET   = 4'd3;

  typedef struct packed {
    logic       tick;
    logic       key_valid;
    logic [3:0] key_value;
    logic [7:0] switches;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] digits_entered;
    logic [1:0] indicator;
    logic [1:0] alarm_reason;
    logic [2:0] tripped_zone;
  } out_item_t;

  typedef struct packed {
    logic [15:0] secret_code;
    logic [7:0]  exit_seconds;
    logic [7:0]  entry_seconds;
    logic [7:0]  alarm_seconds;
    logic [3:0]  wrong_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic       full_nz;
    logic       ee_nz;
    logic [2:0] top_zone;
  } zone_info_t;

endpackage

// ===== sv/kiac_regs.sv =====
module kiac_regs
  import kiac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_regs_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code   <= SECRET_CODE_RESET;
      cfg.exit_seconds  <= EXIT_SECONDS_RESET;
      cfg.entry_seconds <= ENTRY_SECONDS_RESET;
      cfg.alarm_seconds <= ALARM_SECONDS_RESET;
      cfg.wrong_limit   <= WRONG_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECRET_CODE:   cfg.secret_code   <= cfg_data;
        REG_EXIT_SECONDS:  cfg.exit_seconds  <= cfg_data[7:0];
        REG_ENTRY_SECONDS: cfg.entry_seconds <= cfg_data[7:0];
        REG_ALARM_SECONDS: cfg.alarm_seconds <= cfg_data[7:0];
        REG_WRONG_LIMIT:   cfg.wrong_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/kiac_zone.sv =====
module kiac_zone
  import kiac_pkg::*;
(
  input  logic [7:0] switches,
  output zone_info_t zone
);

  // Divide by ten as a multiply by 205/2048, exact for all 8-bit inputs.
  logic [15:0] prod;
  logic [4:0]  quot;
  logic [7:0]  full;
  logic [7:0]  rem;

  assign prod = 16'(switches) * 16'd205;
  assign quot = prod[15:11];
  assign full = 8'(quot) * 8'd10;
  assign rem  = switches - full;

  always_comb begin
    zone.full_nz  = (full != 8'd0);
    zone.ee_nz    = (rem != 8'd0);
    zone.top_zone = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (full[i]) zone.top_zone = 3'(i);
    end
  end

endmodule

// ===== sv/kiac_core.sv =====
module kiac_core
  import kiac_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_item_t   item,
  input  zone_info_t zone,
  input  cfg_regs_t  cfg,
  output out_item_t  result
);

  localparam int W  = 4 * CODE_DIGITS;
  localparam int CW = $clog2(CODE_DIGITS + 1);

  mode_t         mode, mode_next;
  logic [W-1:0]  code_buf, code_buf_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [3:0]    tries, tries_next;
  logic [7:0]    secs, secs_next;
  logic [1:0]    lamp, lamp_next;
  logic [1:0]    reason, reason_next;
  logic [2:0]    zone_reg, zone_next;

  logic [7:0]    secs_t;
  logic [W-1:0]  buf_e;
  logic [CW-1:0] cnt_e;
  logic          submit;
  logic          match;
  logic [W+15:0] code_wide;
  logic [W-1:0]  code_ext;
  logic [3:0]    tries_inc;
  logic [3:0]    limit;
  logic          go;
  mode_t         go_mode;
  logic [CW+2:0] cnt_wide;

  assign code_wide = {{W{1'b0}}, cfg.secret_code};
  assign code_ext  = code_wide[W-1:0];
  assign secs_t    = (item.tick && secs != 8'hFF) ? secs + 8'd1 : secs;
  assign tries_inc = (tries == 4'hF) ? tries : tries + 4'd1;
  assign limit     = (cfg.wrong_limit == 4'd0) ? 4'd1 : cfg.wrong_limit;

  // Buffer editing while the buffer is not full: digits shift in at the bottom, C drops the last digit.
  always_comb begin
    buf_e = code_buf;
    cnt_e = cnt;
    if (item.key_valid && cnt != CW'(CODE_DIGITS)) begin
      if (item.key_value <= 4'd9) begin
        buf_e = (code_buf << 4) | W'(item.key_value);
        cnt_e = cnt + CW'(1);
      end else if (item.key_value == KEY_C && cnt != CW'(0)) begin
        buf_e = code_buf >> 4;
        cnt_e = cnt - CW'(1);
      end
    end
  end

  assign submit = item.key_valid && item.key_value == KEY_B && cnt_e == CW'(CODE_DIGITS);
  assign match  = (buf_e == code_ext);

  // Next-state logic.
  always_comb begin
    mode_next     = mode;
    code_buf_next = code_buf;
    cnt_next      = cnt;
    tries_next    = tries;
    secs_next     = secs_t;
    lamp_next     = lamp;
    reason_next   = reason;
    zone_next     = zone_reg;
    go            = 1'b0;
    go_mode       = MODE_UNSET;
    case (mode)
      MODE_UNSET, MODE_EXIT: begin
        if (mode == MODE_EXIT && secs_t >= cfg.exit_seconds) begin
          go      = 1'b1;
          go_mode = MODE_SET;
        end else if (mode == MODE_EXIT && zone.full_nz) begin
          reason_next = REASON_ZONE;
          zone_next   = zone.top_zone;
          go          = 1'b1;
          go_mode     = MODE_ALARM;
        end else begin
          code_buf_next = buf_e;
          cnt_next      = cnt_e;
          if (submit) begin
            if (match) begin
              go      = 1'b1;
              go_mode = (mode == MODE_UNSET) ? MODE_EXIT : MODE_UNSET;
            end else begin
              code_buf_next = '0;
              cnt_next      = '0;
              tries_next    = tries_inc;
              if (tries_inc >= limit) begin
                reason_next = REASON_WRONG;
                zone_next   = 3'd0;
                go          = 1'b1;
                go_mode     = MODE_ALARM;
              end
            end
          end
        end
      end
      MODE_SET: begin
        if (zone.full_nz) begin
          reason_next = REASON_ZONE;
          zone_next   = zone.top_zone;
          go          = 1'b1;
          go_mode     = MODE_ALARM;
        end else if (zone.ee_nz) begin
          go      = 1'b1;
          go_mode = MODE_ENTRY;
        end
      end
      MODE_ENTRY: begin
        if (secs_t >= cfg.entry_seconds) begin
          reason_next = REASON_TIMEOUT;
          zone_next   = 3'd0;
          go          = 1'b1;
          go_mode     = MODE_ALARM;
        end else if (zone.full_nz) begin
          reason_next = REASON_ZONE;
          zone_next   = zone.top_zone;
          go          = 1'b1;
          go_mode     = MODE_ALARM;
        end else begin
          code_buf_next = buf_e;
          cnt_next      = cnt_e;
          if (submit) begin
            if (match) begin
              go      = 1'b1;
              go_mode = MODE_UNSET;
            end else begin
              code_buf_next = '0;
              cnt_next      = '0;
            end
          end
        end
      end
      MODE_ALARM: begin
        if (secs_t >= cfg.alarm_seconds) lamp_next = LAMP_OFF;
        code_buf_next = buf_e;
        cnt_next      = cnt_e;
        if (submit) begin
          if (match) begin
            go      = 1'b1;
            go_mode = MODE_REPORT;
          end else begin
            code_buf_next = '0;
            cnt_next      = '0;
          end
        end
      end
      MODE_REPORT: begin
        code_buf_next = buf_e;
        cnt_next      = cnt_e;
        if (item.key_valid && item.key_value == KEY_C) begin
          reason_next = REASON_NONE;
          zone_next   = 3'd0;
          go          = 1'b1;
          go_mode     = MODE_UNSET;
        end
      end
      default: begin
        go      = 1'b1;
        go_mode = MODE_UNSET;
      end
    endcase
    if (go) begin
      mode_next     = go_mode;
      code_buf_next = '0;
      cnt_next      = '0;
      tries_next    = 4'd0;
      secs_next     = 8'd0;
      if (go_mode == MODE_EXIT || go_mode == MODE_ENTRY) begin
        lamp_next = LAMP_BLINK;
      end else if (go_mode == MODE_ALARM) begin
        lamp_next = LAMP_ON;
      end else begin
        lamp_next = LAMP_OFF;
      end
    end
  end

  // Result fields show the state after the item.
  assign cnt_wide = {3'b000, cnt_next};

  always_comb begin
    result.mode           = mode_next;
    result.digits_entered = cnt_wide[2:0];
    result.indicator      = lamp_next;
    result.alarm_reason   = reason_next;
    result.tripped_zone   = (reason_next == REASON_ZONE) ? zone_next : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_UNSET;
      code_buf <= '0;
      cnt      <= '0;
      tries    <= 4'd0;
      secs     <= 8'd0;
      lamp     <= LAMP_OFF;
      reason   <= REASON_NONE;
      zone_reg <= 3'd0;
    end else if (advance) begin
      mode     <= mode_next;
      code_buf <= code_buf_next;
      cnt      <= cnt_next;
      tries    <= tries_next;
      secs     <= secs_next;
      lamp     <= lamp_next;
      reason   <= reason_next;
      zone_reg <= zone_next;
    end
  end

endmodule

// ===== sv/keypad_intruder_alarm_controller.sv =====
// Keypad intruder alarm panel. Each input item carries a one-second tick, an
// optional decoded key and the sampled sensor switch word, and produces exactly
// one result item that shows the panel after the item: mode, digits held in the
// code buffer, lamp state, alarm reason and tripped zone. An item is taken into
// an input register, and when it moves on the whole mode update runs through
// one pass of logic into the panel state and the result register, so the
// block accepts one item per clock while out_stall is low, and a result is
// offered once its item has left the input register. The result register
// frees itself in the same cycle it is taken, so a steady stream runs at
// full rate while out_stall is low.
// The five configuration registers (stored code, exit, entry and alarm
// seconds, wrong-code limit) are written through cfg_we, cfg_index and
// cfg_data and should only change while no item is in flight.
module keypad_intruder_alarm_controller
  import kiac_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t  cfg;
  zone_info_t zone;
  out_item_t  result;
  in_item_t   s1_item;
  logic       s1_valid;
  logic       advance;

  // The input stage moves on whenever the result register is empty or is
  // being taken in this same cycle.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= in_item;
  end

  kiac_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The zone split works on the registered switch word.
  kiac_zone u_zone (
    .switches (s1_item.switches),
    .zone     (zone)
  );

  kiac_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .zone    (zone),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= result;
  end

endmodule

// ===== sv/kiac_checker.sv =====
module kiac_checker
  import kiac_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A result held back by the receiver stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_zone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.alarm_reason != REASON_ZONE |-> out_item.tripped_zone == 3'd0)
    else $error("zone shown without zone reason");

  a_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.mode == MODE_EXIT || out_item.mode == MODE_ENTRY)
      |-> out_item.indicator == LAMP_BLINK)
    else $error("delay mode without blinking lamp");

  a_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.mode == MODE_UNSET || out_item.mode == MODE_SET ||
                  out_item.mode == MODE_REPORT) |-> out_item.indicator == LAMP_OFF)
    else $error("lamp lit outside alarm and delays");

  a_set_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.mode == MODE_SET |-> out_item.digits_entered == 3'd0)
    else $error("digits held while set");

endmodule

bind keypad_intruder_alarm_controller kiac_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
